### sv/soa_pkg.sv
// ----------------------------------------------------------------------------
// soa_pkg: shared types and helpers for the sized-operand ALU
// Operation codes, width codes and the record handed along the cell row.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned WideW = 64;
  localparam int unsigned NumCells = DataW;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_AND = 4'd1,
    OP_DIV = 4'd2,
    OP_MOD = 4'd3,
    OP_MUL = 4'd4,
    OP_NEG = 4'd5,
    OP_NOT = 4'd6,
    OP_OR  = 4'd7,
    OP_SHL = 4'd8,
    OP_SHR = 4'd9,
    OP_SUB = 4'd10,
    OP_XOR = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    SZ_8  = 2'd0,
    SZ_16 = 2'd1,
    SZ_19 = 2'd2,
    SZ_32 = 2'd3
  } size_e;

  // Record carried by every cell of the row
  typedef struct packed {
    logic             valid;
    logic [3:0]       op;
    logic [1:0]       size_r;
    logic             sign_a;
    logic             sign_b;
    logic             div_zero;
    logic             borrow;
    logic [WideW-1:0] u;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] divisor;
  } cell_t;

  function automatic logic [WideW-1:0] size_mask(input logic [1:0] code);
    logic [WideW-1:0] m;
    case (code)
      SZ_8:    m = 64'h0000_0000_0000_00ff;
      SZ_16:   m = 64'h0000_0000_0000_ffff;
      SZ_19:   m = 64'h0000_0000_0007_ffff;
      SZ_32:   m = 64'h0000_0000_ffff_ffff;
      default: m = 64'h0000_0000_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic sign_at(input logic [WideW-1:0] v, input logic [1:0] code);
    logic s;
    case (code)
      SZ_8:    s = v[7];
      SZ_16:   s = v[15];
      SZ_19:   s = v[18];
      SZ_32:   s = v[31];
      default: s = v[31];
    endcase
    return s;
  endfunction

  // 2^R for the result width code
  function automatic logic [WideW-1:0] size_span(input logic [1:0] code);
    return size_mask(code) + 64'd1;
  endfunction

endpackage

### sv/soa_prep.sv
// ----------------------------------------------------------------------------
// soa_prep: operand entry stage
// Cuts operands to size, runs every operation but divide and modulo, seeds the divider.
// ----------------------------------------------------------------------------
module soa_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        accept_i,
  input  logic [3:0]                  mode_i,
  input  logic [1:0]                  size_result_i,
  input  logic [1:0]                  size_a_i,
  input  logic [1:0]                  size_b_i,
  input  logic [31:0]                 operand_a_i,
  input  logic [31:0]                 operand_b_i,
  input  logic                        carry_in_i,
  output soa_pkg::cell_t              cell_o
);

  soa_pkg::cell_t cell_d, cell_q;
  logic [63:0] a, b, r, prod, shl_v, span;
  logic        neg_use;

  always_comb begin
    a      = {32'd0, operand_a_i} & soa_pkg::size_mask(size_a_i);
    b      = {32'd0, operand_b_i} & soa_pkg::size_mask(size_b_i);
    prod   = a * b;
    shl_v  = a << b[5:0];
    span   = soa_pkg::size_span(size_result_i);
    neg_use = 1'b1;
    case (mode_i)
      soa_pkg::OP_ADD: r = a + b + {63'd0, carry_in_i};
      soa_pkg::OP_AND: r = a & b;
      soa_pkg::OP_MUL: begin
        r = prod;
        neg_use = 1'b0;
      end
      soa_pkg::OP_NEG: r = 64'd0 - a;
      soa_pkg::OP_NOT: r = ~a;
      soa_pkg::OP_OR:  r = a | b;
      soa_pkg::OP_SHL: begin
        r = shl_v;
        neg_use = 1'b0;
      end
      soa_pkg::OP_SHR: r = a >> b[5:0];
      soa_pkg::OP_SUB: r = a - b + {63'd0, carry_in_i};
      soa_pkg::OP_XOR: r = a ^ b;
      default:         r = 64'd0;
    endcase

    cell_d.valid    = accept_i;
    cell_d.op       = mode_i;
    cell_d.size_r   = size_result_i;
    cell_d.sign_a   = soa_pkg::sign_at(a, size_a_i);
    cell_d.sign_b   = soa_pkg::sign_at(b, size_b_i);
    cell_d.div_zero = (b == 64'd0);
    cell_d.borrow   = (mode_i == soa_pkg::OP_SUB) && r[63];
    cell_d.u        = (neg_use && r[63]) ? r + span : r;
    cell_d.rem      = '0;
    cell_d.quo      = a[31:0];
    cell_d.divisor  = b[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### sv/soa_div_cell.sv
// ----------------------------------------------------------------------------
// soa_div_cell: one restoring-division step
// Produces one quotient bit and passes the whole record to the next cell.
// ----------------------------------------------------------------------------
module soa_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  soa_pkg::cell_t cell_i,
  output soa_pkg::cell_t cell_o
);

  soa_pkg::cell_t cell_d, cell_q;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  always_comb begin
    trial  = {cell_i.rem, cell_i.quo[31]};
    diff   = trial - {1'b0, cell_i.divisor};
    fits   = !diff[32];
    cell_d = cell_i;
    cell_d.rem = fits ? diff[31:0] : trial[31:0];
    cell_d.quo = {cell_i.quo[30:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### sv/soa_flags.sv
// ----------------------------------------------------------------------------
// soa_flags: result and flag stage
// Picks the final value, masks it to the result size and forms the flags.
// ----------------------------------------------------------------------------
module soa_flags (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  soa_pkg::cell_t cell_i,
  output logic           valid_o,
  output logic [31:0]    result_o,
  output logic           carry_flag_o,
  output logic           negative_flag_o,
  output logic           overflow_flag_o,
  output logic           zero_flag_o
);

  logic [63:0] u, mask, res;
  logic        neg, cf, vf, zf, dz;
  logic        valid_q;
  logic [31:0] result_d, result_q;
  logic [3:0]  flags_d, flags_q;

  always_comb begin
    case (cell_i.op)
      soa_pkg::OP_DIV: u = {32'd0, cell_i.quo};
      soa_pkg::OP_MOD: u = {32'd0, cell_i.rem};
      default:         u = cell_i.u;
    endcase
    mask = soa_pkg::size_mask(cell_i.size_r);
    res  = u & mask;
    neg  = soa_pkg::sign_at(u, cell_i.size_r);
    cf   = ((u & ~mask) != 64'd0) || cell_i.borrow;
    zf   = (res == 64'd0);
    vf   = 1'b0;
    if (cell_i.sign_a != neg) begin
      if (cell_i.op == soa_pkg::OP_ADD || cell_i.op == soa_pkg::OP_MUL) begin
        vf = (cell_i.sign_a == cell_i.sign_b);
      end else if (cell_i.op == soa_pkg::OP_SUB) begin
        vf = (cell_i.sign_a != cell_i.sign_b);
      end
    end
    dz = cell_i.div_zero &&
         (cell_i.op == soa_pkg::OP_DIV || cell_i.op == soa_pkg::OP_MOD);
    if (dz) begin
      result_d = '0;
      flags_d  = 4'b1111;
    end else begin
      result_d = res[31:0];
      flags_d  = {cf, neg, vf, zf};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= result_d;
      flags_q  <= flags_d;
    end
  end

  assign valid_o         = valid_q;
  assign result_o        = result_q;
  assign carry_flag_o    = flags_q[3];
  assign negative_flag_o = flags_q[2];
  assign overflow_flag_o = flags_q[1];
  assign zero_flag_o     = flags_q[0];

endmodule

### sv/sized_operand_alu.sv
// ----------------------------------------------------------------------------
// sized_operand_alu: integer ALU with per-operand sizes and flags
// Entry stage, a row of 32 division cells and a result stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one operation per transaction
//   (mode, sizes, operands, carry in). Output channel: out_valid_o /
//   out_stall_i carry the masked result and the four flags.
//   From acceptance to result valid a transaction passes the entry stage, one
//   cell per quotient bit of the 32-bit divider and the result register. Every
//   operation flows through the same row so results keep their order.
//   Throughput: one transaction per cycle unless stalled; the row is pipelined.
//   Reset clears all valid bits; the block accepts once reset is released.
//   When the receiver stalls a valid result, the whole row holds and
//   in_stall_o rises in the same cycle; it drops as soon as the result goes.
// ----------------------------------------------------------------------------
module sized_operand_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  mode_i,
  input  logic [1:0]  size_result_i,
  input  logic [1:0]  size_a_i,
  input  logic [1:0]  size_b_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        carry_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_o,
  output logic        carry_flag_o,
  output logic        negative_flag_o,
  output logic        overflow_flag_o,
  output logic        zero_flag_o
);

  soa_pkg::cell_t chain [soa_pkg::NumCells+1];
  logic en;
  logic out_valid;

  // hold everything while a finished result waits
  assign en         = !(out_valid && out_stall_i);
  assign in_stall_o = !en;

  soa_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .accept_i      (in_valid_i),
    .mode_i        (mode_i),
    .size_result_i (size_result_i),
    .size_a_i      (size_a_i),
    .size_b_i      (size_b_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .carry_in_i    (carry_in_i),
    .cell_o        (chain[0])
  );

  for (genvar i = 0; i < soa_pkg::NumCells; i++) begin : g_cell
    soa_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  soa_flags u_flags (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .cell_i          (chain[soa_pkg::NumCells]),
    .valid_o         (out_valid),
    .result_o        (result_o),
    .carry_flag_o    (carry_flag_o),
    .negative_flag_o (negative_flag_o),
    .overflow_flag_o (overflow_flag_o),
    .zero_flag_o     (zero_flag_o)
  );

  assign out_valid_o = out_valid;

endmodule
